>>> hdl/rmst_pkg.sv
`default_nettype none

package rmst_pkg;

    localparam int ADDR_BITS  = 10;
    localparam int CAPACITY   = 1 << ADDR_BITS;
    localparam int LEVELS     = ADDR_BITS + 1;
    localparam int IDX_BITS   = ADDR_BITS + 1;
    // one spare code so a level counter can step one past the top level
    localparam int LEVEL_BITS = $clog2(LEVELS + 1);
    localparam int MEM_DEPTH  = LEVELS * CAPACITY;
    localparam int MEM_ABITS  = $clog2(MEM_DEPTH);
    localparam int DATA_BITS  = 32;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]                  opcode;
        logic signed [DATA_BITS-1:0] value;
        logic [IDX_BITS-1:0]         left;
        logic [IDX_BITS-1:0]         right;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] minimum;
        logic                        error;
    } out_beat_t;

    function automatic logic [LEVEL_BITS-1:0] floor_log2(input logic [IDX_BITS-1:0] x);
        logic [LEVEL_BITS-1:0] result;
        result = '0;
        for (int i = 0; i < IDX_BITS; i++) begin
            if (x[i]) begin
                result = LEVEL_BITS'(i);
            end
        end
        return result;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rmst_ram.sv
`default_nettype none

module rmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/range_minimum_sparse_table.sv
`default_nettype none

// Range-minimum sparse table of up to 1024 signed 32-bit elements, held in one
// 11 x 1024 word RAM (level j, entry i = min of elements i .. i+2^j-1) with one
// write and one registered read port. The block takes one beat at a time and is
// not ready while it works. A clear gives no result. An append refreshes k =
// floor(log2(n+1)) upper levels for the new element at position n; a rejected
// append or an invalid query returns the error flag instead. The upper-level
// fill runs one level per cycle through the single compare unit and RAM port;
// the query is bound by its two RAM reads.
// A finished result sits in the output register, so the next beat is accepted
// while it waits. The RAM needs no clearing after reset.
module range_minimum_sparse_table
    import rmst_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LEVEL,
        S_QRY_B,
        S_QRY_MIN,
        S_RESP
    } state_t;

    state_t                      state_reg, state_next;
    in_beat_t                    item_reg, item_next;
    logic [IDX_BITS-1:0]         count_reg, count_next;
    logic [LEVEL_BITS-1:0]       level_reg, level_next;
    logic signed [DATA_BITS-1:0] carry_reg, carry_next;
    logic [MEM_ABITS-1:0]        qaddr_reg, qaddr_next;
    out_beat_t                   res_reg, res_next;
    logic                        m_valid_reg, m_valid_next;
    out_beat_t                   m_data_reg, m_data_next;

    logic                        ram_we, ram_re;
    logic [MEM_ABITS-1:0]        ram_waddr, ram_raddr;
    logic [DATA_BITS-1:0]        ram_wdata, ram_rdata;

    logic [IDX_BITS-1:0]         pos1;
    logic [LEVEL_BITS-1:0]       level_up;
    logic signed [DATA_BITS-1:0] lvl_min, qry_min;
    logic [IDX_BITS-1:0]         qry_len;
    logic [LEVEL_BITS-1:0]       qry_lvl;
    logic [IDX_BITS-1:0]         qry_second;
    logic                        qry_bad;
    logic                        out_free;

    function automatic logic [MEM_ABITS-1:0] mem_addr(input logic [LEVEL_BITS-1:0] lvl,
                                                      input logic [ADDR_BITS-1:0] idx);
        return MEM_ABITS'({lvl, idx});
    endfunction

    // level lvl has an entry ending at the new element
    function automatic logic level_live(input logic [LEVEL_BITS-1:0] lvl,
                                        input logic [IDX_BITS-1:0] end_pos);
        return (lvl < LEVEL_BITS'(LEVELS)) && ((end_pos >> lvl) != '0);
    endfunction

    function automatic logic [ADDR_BITS-1:0] span_start(input logic [LEVEL_BITS-1:0] lvl,
                                                        input logic [IDX_BITS-1:0] end_pos);
        logic [IDX_BITS-1:0] s;
        s = end_pos - (IDX_BITS'(1) << lvl);
        return s[ADDR_BITS-1:0];
    endfunction

    rmst_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pos1       = count_reg + IDX_BITS'(1);
    assign level_up   = level_reg + LEVEL_BITS'(1);
    assign lvl_min    = ($signed(ram_rdata) < carry_reg) ? $signed(ram_rdata) : carry_reg;
    assign qry_min    = lvl_min;
    assign qry_len    = item_reg.right - item_reg.left;
    assign qry_lvl    = floor_log2(qry_len);
    assign qry_second = item_reg.right - (IDX_BITS'(1) << qry_lvl);
    assign qry_bad    = (item_reg.left >= item_reg.right) || (item_reg.right > count_reg);
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        count_next   = count_reg;
        level_next   = level_reg;
        carry_next   = carry_reg;
        qaddr_next   = qaddr_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (item_reg.opcode)
                    OP_CLEAR: begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    OP_APPEND: begin
                        if (count_reg >= IDX_BITS'(CAPACITY)) begin
                            res_next   = '{minimum: '0, error: 1'b1};
                            state_next = S_RESP;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = mem_addr('0, count_reg[ADDR_BITS-1:0]);
                            ram_wdata  = item_reg.value;
                            carry_next = item_reg.value;
                            level_next = LEVEL_BITS'(1);
                            if (level_live(LEVEL_BITS'(1), pos1)) begin
                                // lower half of the level-1 span
                                ram_re     = 1'b1;
                                ram_raddr  = mem_addr('0, span_start(LEVEL_BITS'(1), pos1));
                                state_next = S_LEVEL;
                            end else begin
                                count_next = pos1;
                                res_next   = '{minimum: '0, error: 1'b0};
                                state_next = S_RESP;
                            end
                        end
                    end
                    OP_QUERY: begin
                        if (qry_bad) begin
                            res_next   = '{minimum: '0, error: 1'b1};
                            state_next = S_RESP;
                        end else begin
                            ram_re     = 1'b1;
                            ram_raddr  = mem_addr(qry_lvl, item_reg.left[ADDR_BITS-1:0]);
                            qaddr_next = mem_addr(qry_lvl, qry_second[ADDR_BITS-1:0]);
                            state_next = S_QRY_B;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LEVEL: begin
                // upper half is the entry written in the previous cycle, held in carry
                ram_we     = 1'b1;
                ram_waddr  = mem_addr(level_reg, span_start(level_reg, pos1));
                ram_wdata  = lvl_min;
                carry_next = lvl_min;
                level_next = level_up;
                if (level_live(level_up, pos1)) begin
                    ram_re    = 1'b1;
                    ram_raddr = mem_addr(level_reg, span_start(level_up, pos1));
                end else begin
                    count_next = pos1;
                    res_next   = '{minimum: '0, error: 1'b0};
                    state_next = S_RESP;
                end
            end
            S_QRY_B: begin
                ram_re     = 1'b1;
                ram_raddr  = qaddr_reg;
                carry_next = $signed(ram_rdata);
                state_next = S_QRY_MIN;
            end
            S_QRY_MIN: begin
                res_next   = '{minimum: qry_min, error: 1'b0};
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        level_reg  <= level_next;
        carry_reg  <= carry_next;
        qaddr_reg  <= qaddr_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
